// ----- rtl/core/decimal_word_tx_queue_assert.svh -----
// Assertion helpers included by the top-level RTL.
`ifndef DECIMAL_WORD_TX_QUEUE_ASSERT_SVH
`define DECIMAL_WORD_TX_QUEUE_ASSERT_SVH

// Plain property, sampled on clk, off during reset.
`define DWTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, off during reset.
`define DWTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dwtq_pkg.sv -----
`default_nettype none
package dwtq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 32;
  localparam int RECORD_LEN          = 6;
  localparam int LAST_DIGIT_STEP     = 4;
  localparam logic [7:0]  DIGIT_BASE      = 8'h30;
  localparam logic [7:0]  CARRIAGE_RETURN = 8'h0D;
  localparam logic [16:0] RECIP_10        = 17'd52429;
  localparam int          RECIP_SHIFT     = 19;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_WORD = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_SKIPPED  = 2'd0,
    STAT_QUEUED   = 2'd1,
    STAT_REJECTED = 2'd2,
    STAT_TICK     = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
  } task_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    status_t    status;
    logic [5:0] free_space;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/dwtq_fifo.sv -----
`default_nettype none
module dwtq_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  // two-entry queue
  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

// ----- rtl/core/dwtq_front.sv -----
`default_nettype none
module dwtq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  logic           in_command,
  input  logic [15:0]    in_word_value,
  input  logic           task_full,
  output logic           task_push,
  output dwtq_pkg::task_t task_data
);
  import dwtq_pkg::*;

  logic [15:0] last_word_r;
  kind_t       kind;

  always_comb begin
    if (in_command) begin
      kind = KIND_TICK;
    end else if (in_word_value == last_word_r) begin
      kind = KIND_SKIP;
    end else begin
      kind = KIND_WORD;
    end
  end

  assign task_push       = in_push && !task_full;
  assign task_data.kind  = kind;
  assign task_data.value = in_word_value;

  // last word follows every new value, queued or not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_word_r <= 16'd0;
    end else if (task_push && kind == KIND_WORD) begin
      last_word_r <= in_word_value;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/dwtq_back.sv -----
`default_nettype none
module dwtq_back #(
  parameter int QUEUE_DEPTH = dwtq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             task_valid,
  input  dwtq_pkg::task_t  task_data,
  output logic             task_pop,
  input  logic             res_full,
  output logic             res_push,
  output dwtq_pkg::result_t res_data
);
  import dwtq_pkg::*;

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int FCW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIGIT,
    ST_CR
  } state_t;

  state_t         state_r;
  logic [7:0]     ring_r [QUEUE_DEPTH];
  logic [7:0]     rdata_r;
  logic [PW-1:0]  wp_r;
  logic [PW-1:0]  rp_r;
  logic [FCW-1:0] free_r;
  logic [15:0]    val_r;
  logic [2:0]     step_r;

  logic           start;
  logic           ring_empty;
  logic           room;
  logic [32:0]    prod;
  logic [15:0]    quot;
  logic [15:0]    rem;
  logic [7:0]     digit;
  logic           mem_we;
  logic           mem_re;
  logic [PW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;

  function automatic logic [PW-1:0] wrap_pos(input logic [PW:0] sum);
    if (sum >= (PW+1)'(QUEUE_DEPTH)) begin
      return PW'(sum - (PW+1)'(QUEUE_DEPTH));
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [5:0] to_space(input logic [FCW-1:0] f);
    logic [FCW+5:0] ext;
    ext = {6'b0, f};
    return ext[5:0];
  endfunction

  assign start      = (state_r == ST_IDLE) && task_valid && !res_full;
  assign ring_empty = (free_r == FCW'(QUEUE_DEPTH));
  assign room       = (free_r >= FCW'(RECORD_LEN));

  // divide by ten through the reciprocal, one digit per cycle, low digit first
  assign prod  = 33'(val_r) * 33'(RECIP_10);
  assign quot  = 16'(prod >> RECIP_SHIFT);
  assign rem   = val_r - ((quot << 3) + (quot << 1));
  assign digit = DIGIT_BASE + {4'b0, rem[3:0]};

  always_comb begin
    task_pop  = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = digit;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          task_pop = 1'b1;
          res_data.free_space = to_space(free_r);
          unique case (task_data.kind)
            KIND_TICK: begin
              res_data.status = STAT_TICK;
              if (ring_empty) begin
                res_push = 1'b1;
              end else begin
                mem_re = 1'b1;
              end
            end
            KIND_WORD: begin
              res_data.status = STAT_REJECTED;
              res_push        = !room;
            end
            KIND_SKIP: begin
              res_data.status = STAT_SKIPPED;
              res_push        = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_push            = 1'b1;
        res_data.tx_valid   = 1'b1;
        res_data.tx_byte    = rdata_r;
        res_data.status     = STAT_TICK;
        res_data.free_space = to_space(free_r);
      end
      ST_DIGIT: begin
        mem_we    = 1'b1;
        mem_waddr = wrap_pos({1'b0, wp_r} + (PW+1)'(3'(LAST_DIGIT_STEP) - step_r));
        mem_wdata = digit;
      end
      ST_CR: begin
        mem_we              = 1'b1;
        mem_waddr           = wrap_pos({1'b0, wp_r} + (PW+1)'(RECORD_LEN - 1));
        mem_wdata           = CARRIAGE_RETURN;
        res_push            = 1'b1;
        res_data.status     = STAT_QUEUED;
        res_data.free_space = to_space(free_r - FCW'(RECORD_LEN));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      free_r  <= FCW'(QUEUE_DEPTH);
      val_r   <= 16'd0;
      step_r  <= 3'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start && task_data.kind == KIND_TICK && !ring_empty) begin
            rp_r    <= wrap_pos({1'b0, rp_r} + (PW+1)'(1));
            free_r  <= free_r + FCW'(1);
            state_r <= ST_READ;
          end else if (start && task_data.kind == KIND_WORD && room) begin
            val_r   <= task_data.value;
            step_r  <= 3'd0;
            state_r <= ST_DIGIT;
          end
        end
        ST_READ: begin
          state_r <= ST_IDLE;
        end
        ST_DIGIT: begin
          val_r  <= quot;
          step_r <= step_r + 3'd1;
          if (step_r == 3'(LAST_DIGIT_STEP)) state_r <= ST_CR;
        end
        ST_CR: begin
          wp_r    <= wrap_pos({1'b0, wp_r} + (PW+1)'(RECORD_LEN));
          free_r  <= free_r - FCW'(RECORD_LEN);
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring_r[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= ring_r[rp_r];
  end

endmodule
`default_nettype wire

// ----- rtl/core/decimal_word_tx_queue.sv -----
// Transmit queue for decimal readouts.
// Input side is a queue: drive in_command/in_word_value, raise in_push; the
// word is taken on a clock edge where in_full is low. Command 0 queues a value,
// command 1 is a transmitter tick that pops one byte from the ring.
// Result side is a queue too: one result word per input word, in order, shown
// while out_empty is low and taken on a clock edge with out_pop high.
// A new value becomes five ASCII digits plus a carriage return written into
// the ring, one byte per cycle through its single write port.
// The back end takes one skip, reject or empty-ring tick per cycle while the
// output queue has room; a popping tick reads the ring and then returns the
// byte, and a queued word takes five digit steps and the CR write, each task
// finishing before the next is dispatched.
// A two-entry work queue lets input words be taken while the back end writes.
// If the receiver stalls, results wait in a two-entry output queue; once it is
// full the back end holds, the work queue fills and in_full rises.
// Synchronous reset: both queues empty, the ring empty with all places free,
// and the last value 0, so a first value of 0 is skipped.
`default_nettype none
module decimal_word_tx_queue #(
  parameter int QUEUE_DEPTH = dwtq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_command,
  input  logic [15:0] in_word_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic [1:0]  out_word_status,
  output logic [5:0]  out_free_space
);
  import dwtq_pkg::*;

  task_t   front_task;
  task_t   back_task;
  logic    task_push;
  logic    task_full;
  logic    task_empty;
  logic    task_pop;
  result_t back_res;
  result_t out_res;
  logic    res_push;
  logic    res_full;

  dwtq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_command    (in_command),
    .in_word_value (in_word_value),
    .task_full     (task_full),
    .task_push     (task_push),
    .task_data     (front_task)
  );

  dwtq_fifo #(.WIDTH($bits(task_t))) u_task_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (task_push),
    .wdata (front_task),
    .full  (task_full),
    .pop   (task_pop),
    .rdata (back_task),
    .empty (task_empty)
  );

  dwtq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .task_valid (!task_empty),
    .task_data  (back_task),
    .task_pop   (task_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (back_res)
  );

  dwtq_fifo #(.WIDTH($bits(result_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign in_full         = task_full;
  assign out_tx_valid    = out_res.tx_valid;
  assign out_tx_byte     = out_res.tx_byte;
  assign out_word_status = out_res.status;
  assign out_free_space  = out_res.free_space;

`include "decimal_word_tx_queue_assert.svh"

  `DWTQ_ASSERT_IMP(a_valid_only_on_tick, !out_empty && out_tx_valid,
    out_word_status == STAT_TICK, "tx byte on a non-tick result")
  `DWTQ_ASSERT_IMP(a_idle_byte_zero, !out_empty && !out_tx_valid,
    out_tx_byte == 8'h00, "nonzero tx byte without tx_valid")
  `DWTQ_ASSERT_IMP(a_byte_is_text, !out_empty && out_tx_valid,
    (out_tx_byte >= DIGIT_BASE && out_tx_byte <= DIGIT_BASE + 8'd9) ||
    out_tx_byte == CARRIAGE_RETURN, "popped byte is neither digit nor CR")
  `DWTQ_ASSERT(a_no_push_when_back_full, !(res_push && res_full),
    "result produced with no room in result queue")

endmodule
`default_nettype wire
